@@ hw/rtl/bvs_pkg.sv @@
// Package for block_vibration_statistics: shared widths and defaults.
`default_nettype none

package bvs_pkg;

  // Displacement sample width (signed, 1/256 nm).
  localparam int unsigned DispW = 32;
  // Velocity sample width (signed, 1/256 mm/s).
  localparam int unsigned VelW = 24;
  // Width of one squared velocity; the largest square is 2**46.
  localparam int unsigned SqMagW = 2 * VelW - 1;
  // Width of the integer square root of a mean square.
  localparam int unsigned RootW = VelW;
  // Default largest number of samples in one block.
  localparam int unsigned MaxBlockSamplesDef = 4096;

endpackage

`default_nettype wire

@@ hw/rtl/block_vibration_statistics.sv @@
// Top level of the block vibration statistics unit: front, queue and back joined.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_ready_o    displacement_i, velocity_i, last_sample_i
//   out      source     out_valid_o / out_ready_i  disp_peak_to_peak_o, peak_velocity_o,
//                                                  mean_velocity_o, rms_velocity_o,
//                                                  sample_count_o
//
// The front takes one sample transfer per cycle: a squarer register, then the accumulators.
// A closing block goes through the back's serial divider and then its serial root before the
// result is offered. Two finished blocks can wait in the queue, so the front stalls only when
// a closing sample finds the queue full, as when short blocks are closed back to back or while
// the result register is held.
// Reset is asynchronous and active low; it empties the queue and clears every accumulator.
`default_nettype none

module block_vibration_statistics #(
  parameter int unsigned MaxBlockSamples = bvs_pkg::MaxBlockSamplesDef,
  parameter int unsigned CntW = $clog2(MaxBlockSamples + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [bvs_pkg::DispW-1:0] displacement_i,
  input  logic signed [bvs_pkg::VelW-1:0]  velocity_i,
  input  logic                             last_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bvs_pkg::DispW-1:0]        disp_peak_to_peak_o,
  output logic signed [bvs_pkg::VelW-1:0]  peak_velocity_o,
  output logic signed [bvs_pkg::VelW-1:0]  mean_velocity_o,
  output logic [bvs_pkg::RootW-1:0]        rms_velocity_o,
  output logic [CntW-1:0]                  sample_count_o
);

  localparam int unsigned DispW = bvs_pkg::DispW;
  localparam int unsigned VelW  = bvs_pkg::VelW;
  localparam int unsigned RootW = bvs_pkg::RootW;
  // The velocity sum and the sum of squares grow by one bit per doubling of the block size.
  localparam int unsigned SumW  = VelW + $clog2(MaxBlockSamples);
  localparam int unsigned SqW   = bvs_pkg::SqMagW + $clog2(MaxBlockSamples);
  localparam int unsigned EntW  = 2 * DispW + VelW + SumW + SqW + CntW;

  // Fields of one finished block as the front hands it over.
  logic signed [DispW-1:0] f_max;
  logic signed [DispW-1:0] f_min;
  logic signed [VelW-1:0]  f_peak;
  logic signed [SumW-1:0]  f_sum;
  logic [SqW-1:0]          f_sqsum;
  logic [CntW-1:0]         f_count;

  // The same fields as the back reads them from the head of the queue.
  logic signed [DispW-1:0] b_max;
  logic signed [DispW-1:0] b_min;
  logic signed [VelW-1:0]  b_peak;
  logic signed [SumW-1:0]  b_sum;
  logic [SqW-1:0]          b_sqsum;
  logic [CntW-1:0]         b_count;

  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic [EntW-1:0] q_wdata;
  logic [EntW-1:0] q_rdata;

  bvs_front #(
    .MaxBlockSamples (MaxBlockSamples),
    .CntW            (CntW),
    .SumW            (SumW),
    .SqW             (SqW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .displacement_i   (displacement_i),
    .velocity_i       (velocity_i),
    .last_sample_i    (last_sample_i),
    .push_o           (q_push),
    .full_i           (q_full),
    .disp_max_o       (f_max),
    .disp_min_o       (f_min),
    .vel_peak_o       (f_peak),
    .vel_sum_o        (f_sum),
    .vel_square_sum_o (f_sqsum),
    .count_o          (f_count)
  );

  assign q_wdata = {f_max, f_min, f_peak, f_sum, f_sqsum, f_count};

  bvs_fifo #(
    .Width (EntW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_max, b_min, b_peak, b_sum, b_sqsum, b_count} = q_rdata;

  bvs_back #(
    .MaxBlockSamples (MaxBlockSamples),
    .CntW            (CntW),
    .SumW            (SumW),
    .SqW             (SqW)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .empty_i             (q_empty),
    .pop_o               (q_pop),
    .disp_max_i          (b_max),
    .disp_min_i          (b_min),
    .vel_peak_i          (b_peak),
    .vel_sum_i           (b_sum),
    .vel_square_sum_i    (b_sqsum),
    .count_i             (b_count),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .disp_peak_to_peak_o (disp_peak_to_peak_o),
    .peak_velocity_o     (peak_velocity_o),
    .mean_velocity_o     (mean_velocity_o),
    .rms_velocity_o      (rms_velocity_o),
    .sample_count_o      (sample_count_o)
  );

`ifndef SYNTHESIS
  // The front must hold a closing sample back while the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("block pushed into a full queue");

  // The back must only take a block from a queue that holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("block taken from an empty queue");

  // A finished block holds at least one sample and never more than the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != '0) && (sample_count_o <= CntW'(MaxBlockSamples)))
    else $error("sample count of a finished block out of range");

  // The root of a mean of squares of velocity samples cannot exceed the largest magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rms_velocity_o <= (RootW'(1) << (RootW - 1))))
    else $error("rms velocity out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/bvs_fifo.sv @@
// Two-entry queue between the accumulating front and the arithmetic back.
`default_nettype none

module bvs_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned Depth = 2;

  logic [Width-1:0] mem_q [Depth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (fill_q == 2'(Depth));
  assign empty_o = (fill_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bvs_front.sv @@
// Sample front end: squares each velocity and keeps the running block accumulators.
`default_nettype none

module bvs_front #(
  parameter int unsigned MaxBlockSamples = bvs_pkg::MaxBlockSamplesDef,
  parameter int unsigned CntW = $clog2(MaxBlockSamples + 1),
  parameter int unsigned SumW = bvs_pkg::VelW + $clog2(MaxBlockSamples),
  parameter int unsigned SqW  = bvs_pkg::SqMagW + $clog2(MaxBlockSamples)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [bvs_pkg::DispW-1:0] displacement_i,
  input  logic signed [bvs_pkg::VelW-1:0]  velocity_i,
  input  logic                             last_sample_i,
  output logic                             push_o,
  input  logic                             full_i,
  output logic signed [bvs_pkg::DispW-1:0] disp_max_o,
  output logic signed [bvs_pkg::DispW-1:0] disp_min_o,
  output logic signed [bvs_pkg::VelW-1:0]  vel_peak_o,
  output logic signed [SumW-1:0]           vel_sum_o,
  output logic [SqW-1:0]                   vel_square_sum_o,
  output logic [CntW-1:0]                  count_o
);

  localparam int unsigned DispW = bvs_pkg::DispW;
  localparam int unsigned VelW  = bvs_pkg::VelW;
  localparam int unsigned SqMagW = bvs_pkg::SqMagW;

  // Sample register behind the squarer.
  logic                    s1_valid_q;
  logic signed [DispW-1:0] s1_disp_q;
  logic signed [VelW-1:0]  s1_vel_q;
  logic [SqMagW-1:0]       s1_sq_q;
  logic                    s1_last_q;

  // Block accumulators.
  logic signed [DispW-1:0] min_q, min_d;
  logic signed [DispW-1:0] max_q, max_d;
  logic signed [VelW-1:0]  peak_q, peak_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [SqW-1:0]          sqsum_q, sqsum_d;
  logic [CntW-1:0]         count_q, count_d;

  logic signed [2*VelW-1:0] product;
  logic [VelW-1:0]          mag_new;
  logic [VelW-1:0]          mag_peak;
  logic                     first;
  logic                     close;
  logic                     advance;

  assign product = velocity_i * velocity_i;

  assign first    = (count_q == '0);
  assign mag_new  = s1_vel_q[VelW-1] ? (~s1_vel_q + 1'b1) : s1_vel_q;
  assign mag_peak = peak_q[VelW-1] ? (~peak_q + 1'b1) : peak_q;

  always_comb begin
    min_d   = (first || (s1_disp_q < min_q)) ? s1_disp_q : min_q;
    max_d   = (first || (s1_disp_q > max_q)) ? s1_disp_q : max_q;
    peak_d  = (mag_new > mag_peak) ? s1_vel_q : peak_q;
    sum_d   = sum_q + SumW'(s1_vel_q);
    sqsum_d = sqsum_q + SqW'(s1_sq_q);
    count_d = count_q + 1'b1;
  end

  // A block closes on its flagged last sample or when it reaches the size limit.
  assign close      = s1_last_q || (count_d == CntW'(MaxBlockSamples));
  assign advance    = s1_valid_q && (!close || !full_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign push_o     = advance && close;

  assign disp_max_o       = max_d;
  assign disp_min_o       = min_d;
  assign vel_peak_o       = peak_d;
  assign vel_sum_o        = sum_d;
  assign vel_square_sum_o = sqsum_d;
  assign count_o          = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_disp_q <= displacement_i;
      s1_vel_q  <= velocity_i;
      s1_sq_q   <= product[SqMagW-1:0];
      s1_last_q <= last_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= '0;
      peak_q  <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      count_q <= '0;
    end else if (advance) begin
      if (close) begin
        min_q   <= '0;
        max_q   <= '0;
        peak_q  <= '0;
        sum_q   <= '0;
        sqsum_q <= '0;
        count_q <= '0;
      end else begin
        min_q   <= min_d;
        max_q   <= max_d;
        peak_q  <= peak_d;
        sum_q   <= sum_d;
        sqsum_q <= sqsum_d;
        count_q <= count_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bvs_back.sv @@
// Result back end: serial divider for mean and mean square, serial root, result register.
`default_nettype none

module bvs_back #(
  parameter int unsigned MaxBlockSamples = bvs_pkg::MaxBlockSamplesDef,
  parameter int unsigned CntW = $clog2(MaxBlockSamples + 1),
  parameter int unsigned SumW = bvs_pkg::VelW + $clog2(MaxBlockSamples),
  parameter int unsigned SqW  = bvs_pkg::SqMagW + $clog2(MaxBlockSamples)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  output logic                             pop_o,
  input  logic signed [bvs_pkg::DispW-1:0] disp_max_i,
  input  logic signed [bvs_pkg::DispW-1:0] disp_min_i,
  input  logic signed [bvs_pkg::VelW-1:0]  vel_peak_i,
  input  logic signed [SumW-1:0]           vel_sum_i,
  input  logic [SqW-1:0]                   vel_square_sum_i,
  input  logic [CntW-1:0]                  count_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bvs_pkg::DispW-1:0]        disp_peak_to_peak_o,
  output logic signed [bvs_pkg::VelW-1:0]  peak_velocity_o,
  output logic signed [bvs_pkg::VelW-1:0]  mean_velocity_o,
  output logic [bvs_pkg::RootW-1:0]        rms_velocity_o,
  output logic [CntW-1:0]                  sample_count_o
);

  localparam int unsigned DispW = bvs_pkg::DispW;
  localparam int unsigned VelW  = bvs_pkg::VelW;
  localparam int unsigned RootW = bvs_pkg::RootW;
  localparam int unsigned OpW   = 2 * RootW;
  localparam int unsigned IterW = $clog2(SqW);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDiv  = 5'b00010,
    StFin  = 5'b00100,
    StRoot = 5'b01000,
    StHold = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [IterW-1:0]        iter_q, iter_d;
  logic [DispW-1:0]        p2p_q;
  logic signed [VelW-1:0]  peak_q;
  logic                    neg_q;
  logic [CntW-1:0]         div_q;
  logic [SqW-1:0]          a_q, a_d;
  logic [SqW-1:0]          b_q, b_d;
  logic [CntW-1:0]         ra_q, ra_d;
  logic [CntW-1:0]         rb_q, rb_d;
  logic signed [VelW-1:0]  mean_q;
  logic [OpW-1:0]          op_q, op_d;
  logic [RootW+1:0]        rrem_q, rrem_d;
  logic [RootW-1:0]        root_q, root_d;

  logic [CntW:0]           ta;
  logic [CntW:0]           tb;
  logic                    ge_a;
  logic                    ge_b;
  logic [RootW+1:0]        tr;
  logic [RootW+1:0]        trial;
  logic                    ge_r;
  logic [SumW-1:0]         sum_abs;
  logic [VelW-1:0]         quot_lo;

  // One quotient bit of each division per cycle.
  always_comb begin
    ta   = {ra_q, a_q[SqW-1]};
    tb   = {rb_q, b_q[SqW-1]};
    ge_a = (ta >= {1'b0, div_q});
    ge_b = (tb >= {1'b0, div_q});
    ra_d = ge_a ? CntW'(ta - {1'b0, div_q}) : ta[CntW-1:0];
    rb_d = ge_b ? CntW'(tb - {1'b0, div_q}) : tb[CntW-1:0];
    a_d  = {a_q[SqW-2:0], ge_a};
    b_d  = {b_q[SqW-2:0], ge_b};
  end

  // One root bit per cycle, two operand bits brought down each time.
  always_comb begin
    tr     = {rrem_q[RootW-1:0], op_q[OpW-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge_r   = (tr >= trial);
    rrem_d = ge_r ? (tr - trial) : tr;
    root_d = {root_q[RootW-2:0], ge_r};
    op_d   = {op_q[OpW-3:0], 2'b00};
  end

  assign sum_abs = vel_sum_i[SumW-1] ? (~vel_sum_i + 1'b1) : vel_sum_i;
  assign quot_lo = a_q[VelW-1:0];

  assign pop_o = (state_q == StIdle) && !empty_i;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = StDiv;
          iter_d  = IterW'(SqW - 1);
        end
      end
      StDiv: begin
        iter_d = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = StFin;
        end
      end
      StFin: begin
        state_d = StRoot;
        iter_d  = IterW'(RootW - 1);
      end
      StRoot: begin
        iter_d = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          p2p_q  <= disp_max_i - disp_min_i;
          peak_q <= vel_peak_i;
          neg_q  <= vel_sum_i[SumW-1];
          div_q  <= count_i;
          a_q    <= SqW'(sum_abs);
          b_q    <= vel_square_sum_i;
          ra_q   <= '0;
          rb_q   <= '0;
        end
      end
      StDiv: begin
        a_q  <= a_d;
        b_q  <= b_d;
        ra_q <= ra_d;
        rb_q <= rb_d;
      end
      StFin: begin
        mean_q <= neg_q ? (~quot_lo + 1'b1) : quot_lo;
        op_q   <= OpW'(b_q);
        rrem_q <= '0;
        root_q <= '0;
      end
      StRoot: begin
        op_q   <= op_d;
        rrem_q <= rrem_d;
        root_q <= root_d;
      end
      StHold: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o         = (state_q == StHold);
  assign disp_peak_to_peak_o = p2p_q;
  assign peak_velocity_o     = peak_q;
  assign mean_velocity_o     = mean_q;
  assign rms_velocity_o      = root_q;
  assign sample_count_o      = div_q;

endmodule

`default_nettype wire

@@ verif/block_vibration_statistics_checker.sv @@
// Checker for block_vibration_statistics: predicts every block result and compares it.
`timescale 1ns / 1ps

module block_vibration_statistics_checker #(
  parameter int unsigned MaxBlockSamples = bvs_pkg::MaxBlockSamplesDef,
  parameter int unsigned CntW = $clog2(MaxBlockSamples + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [bvs_pkg::DispW-1:0] displacement_i,
  input  logic signed [bvs_pkg::VelW-1:0]  velocity_i,
  input  logic                             last_sample_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [bvs_pkg::DispW-1:0]        disp_peak_to_peak_i,
  input  logic signed [bvs_pkg::VelW-1:0]  peak_velocity_i,
  input  logic signed [bvs_pkg::VelW-1:0]  mean_velocity_i,
  input  logic [bvs_pkg::RootW-1:0]        rms_velocity_i,
  input  logic [CntW-1:0]                  sample_count_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  localparam int unsigned DW = bvs_pkg::DispW;
  localparam int unsigned VW = bvs_pkg::VelW;
  localparam int unsigned RW = bvs_pkg::RootW;

  typedef struct {
    logic [DW-1:0]        p2p;
    logic signed [VW-1:0] peak;
    logic signed [VW-1:0] mean;
    logic [RW-1:0]        rms;
    logic [CntW-1:0]      count;
  } block_stats_t;

  block_stats_t expected_stats_q[$];
  block_stats_t want;

  // Running statistics of the block being collected.
  longint      disp_lo;
  longint      disp_hi;
  longint      peak_vel;
  longint      vel_total;
  logic [63:0] square_total;
  int unsigned block_len;
  int unsigned mismatches = 0;

  function automatic longint abs_val(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Largest root whose square does not exceed x, found one bit at a time.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  task automatic clear_block();
    disp_lo = 0;
    disp_hi = 0;
    peak_vel = 0;
    vel_total = 0;
    square_total = '0;
    block_len = 0;
  endtask

  // Folds one sample into the running statistics and, when the block closes
  // (flagged last or full), queues the result the block must produce.
  task automatic absorb_sample(input longint d, input longint v, input logic last);
    block_stats_t res;
    longint       diff;
    longint       mean_q;
    logic [63:0]  mean_sq;
    logic [31:0]  root;
    logic [63:0]  cnt;
    if (block_len == 0) begin
      disp_lo = d;
      disp_hi = d;
    end else begin
      if (d < disp_lo) disp_lo = d;
      if (d > disp_hi) disp_hi = d;
    end
    if (abs_val(v) > abs_val(peak_vel)) peak_vel = v;
    vel_total += v;
    square_total += 64'(v * v);
    block_len++;
    if (last || block_len == MaxBlockSamples) begin
      cnt = 64'(block_len);
      diff = disp_hi - disp_lo;
      mean_q = vel_total / longint'(block_len);
      mean_sq = square_total / cnt;
      root = floor_sqrt(mean_sq);
      res.p2p = diff[DW-1:0];
      res.peak = peak_vel[VW-1:0];
      res.mean = mean_q[VW-1:0];
      res.rms = root[RW-1:0];
      res.count = cnt[CntW-1:0];
      expected_stats_q.push_back(res);
      clear_block();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_block();
      expected_stats_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        absorb_sample(displacement_i, velocity_i, last_sample_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_stats_q.size() == 0) begin
          $error("result transfer with no block outstanding (sample_count %0d)",
                 sample_count_i);
          mismatches++;
        end else begin
          want = expected_stats_q.pop_front();
          if (disp_peak_to_peak_i !== want.p2p) begin
            $error("disp_peak_to_peak: expected %0d, actual %0d", want.p2p,
                   disp_peak_to_peak_i);
            mismatches++;
          end
          if (peak_velocity_i !== want.peak) begin
            $error("peak_velocity: expected %0d, actual %0d", want.peak, peak_velocity_i);
            mismatches++;
          end
          if (mean_velocity_i !== want.mean) begin
            $error("mean_velocity: expected %0d, actual %0d", want.mean, mean_velocity_i);
            mismatches++;
          end
          if (rms_velocity_i !== want.rms) begin
            $error("rms_velocity: expected %0d, actual %0d", want.rms, rms_velocity_i);
            mismatches++;
          end
          if (sample_count_i !== want.count) begin
            $error("sample_count: expected %0d, actual %0d", want.count, sample_count_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o <= expected_stats_q.size();
  end

endmodule

@@ verif/block_vibration_statistics_test.sv @@
// Top of the block_vibration_statistics testbench: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module block_vibration_statistics_test;

  localparam int unsigned DispW = bvs_pkg::DispW;
  localparam int unsigned VelW  = bvs_pkg::VelW;
  localparam int unsigned RootW = bvs_pkg::RootW;
  localparam int unsigned MaxBlock = bvs_pkg::MaxBlockSamplesDef;
  localparam int unsigned CntW = $clog2(MaxBlock + 1);
  // Roughly how many sample transfers the random part offers.
  localparam int unsigned RandomItems = 1450;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int unsigned HoldCycles = 600;
  // Cycles without any transfer before the run is declared hung. The slowest
  // legal stretch is the hold-off plus a few back-end passes.
  localparam int unsigned WatchdogLimit = 5000;
  // Settling time after the last result, well above the back-end latency.
  localparam int unsigned TailCycles = 200;

  localparam logic signed [DispW-1:0] DispMin = {1'b1, {(DispW - 1){1'b0}}};
  localparam logic signed [DispW-1:0] DispMax = {1'b0, {(DispW - 1){1'b1}}};
  localparam logic signed [VelW-1:0]  VelMin  = {1'b1, {(VelW - 1){1'b0}}};
  localparam logic signed [VelW-1:0]  VelMax  = {1'b0, {(VelW - 1){1'b1}}};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [DispW-1:0]   displacement = '0;
  logic signed [VelW-1:0]    velocity = '0;
  logic                      last_sample = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [DispW-1:0]          disp_peak_to_peak;
  logic signed [VelW-1:0]    peak_velocity;
  logic signed [VelW-1:0]    mean_velocity;
  logic [RootW-1:0]          rms_velocity;
  logic [CntW-1:0]           sample_count;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  // Raised by the stimulus to ask the receiver for one long hold-off; the
  // receiver lowers it again once it has started holding.
  bit          drain_hold_req = 1'b0;

  block_vibration_statistics u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .displacement_i      (displacement),
    .velocity_i          (velocity),
    .last_sample_i       (last_sample),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .disp_peak_to_peak_o (disp_peak_to_peak),
    .peak_velocity_o     (peak_velocity),
    .mean_velocity_o     (mean_velocity),
    .rms_velocity_o      (rms_velocity),
    .sample_count_o      (sample_count)
  );

  block_vibration_statistics_checker #(
    .MaxBlockSamples (MaxBlock)
  ) u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .displacement_i      (displacement),
    .velocity_i          (velocity),
    .last_sample_i       (last_sample),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .disp_peak_to_peak_i (disp_peak_to_peak),
    .peak_velocity_i     (peak_velocity),
    .mean_velocity_i     (mean_velocity),
    .rms_velocity_i      (rms_velocity),
    .sample_count_i      (sample_count),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Idle length shared by both sides: mostly nothing or a short gap, now and
  // then a longer pause so that gaps land on every phase of the back end.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Displacements lean on the extremes and on small values of both signs, so
  // that the minimum and maximum are exercised as well as the full bit range.
  function automatic logic signed [DispW-1:0] pick_disp();
    int          s;
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return DispMin;
      1: return DispMax;
      2, 3: begin
        s = int'($urandom_range(0, 2000)) - 1000;
        return s;
      end
      default: return r;
    endcase
  endfunction

  // Velocities: extremes, zero, small values (which make magnitude ties
  // likely) and full-range random words.
  function automatic logic signed [VelW-1:0] pick_vel();
    int          s;
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return VelMin;
      1: return VelMax;
      2: return '0;
      3, 4: begin
        s = int'($urandom_range(0, 200)) - 100;
        return s[VelW-1:0];
      end
      default: return r[VelW-1:0];
    endcase
  endfunction

  // Block lengths are mostly short so that many results come back; a few
  // longer blocks give the sums room to grow.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  // Offers one sample and waits for its transfer. Valid stays high across
  // back-to-back samples, so each falling edge carries at most one update.
  task automatic offer_sample(input logic signed [DispW-1:0] d,
                              input logic signed [VelW-1:0] v,
                              input logic last, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    displacement <= d;
    velocity <= v;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_block(input int unsigned len, input bit steady);
    for (int unsigned i = 0; i < len; i++) begin
      offer_sample(pick_disp(), pick_vel(), i == len - 1, steady);
    end
  endtask

  // The sender stops offering until every result it is owed has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: random stalls with occasional steady stretches, plus the one
  // long hold-off on request. At most one update of ready per falling edge.
  initial begin
    int unsigned stall;
    int unsigned steady_left;
    stall = 0;
    steady_left = 0;
    forever begin
      @(negedge clk);
      if (drain_hold_req) begin
        out_ready <= 1'b0;
        drain_hold_req = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (steady_left != 0) begin
          steady_left--;
        end else if ($urandom_range(0, 9) == 0) begin
          steady_left = $urandom_range(50, 300);
        end else begin
          stall = idle_len();
        end
      end
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("block_vibration_statistics regression: fail");
      $finish;
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Single-sample blocks at the extremes: the most negative
    // velocity gives the largest mean magnitude and root, a zero sample leaves
    // the peak at its start value of zero.
    offer_sample(DispMin, VelMin, 1'b1, 1'b0);
    offer_sample(DispMax, VelMax, 1'b1, 1'b1);
    offer_sample('0, '0, 1'b1, 1'b1);
    // Full displacement span, and a tie in magnitude where the first sample
    // must keep the peak.
    offer_sample(DispMin, 24'sd5, 1'b0, 1'b1);
    offer_sample(DispMax, -24'sd5, 1'b1, 1'b1);
    // Ties again, and a negative mean that must truncate towards zero.
    offer_sample(0, -24'sd7, 1'b0, 1'b0);
    offer_sample(0, 24'sd7, 1'b0, 1'b0);
    offer_sample(0, -24'sd7, 1'b1, 1'b1);
    // Mean of -3.5 truncates to -3; mean square 12.5 floors before the root.
    offer_sample(100, -24'sd3, 1'b0, 1'b1);
    offer_sample(-100, -24'sd4, 1'b1, 1'b1);
    // Largest squares side by side.
    offer_sample(DispMax, VelMax, 1'b0, 1'b1);
    offer_sample(DispMax, VelMax, 1'b0, 1'b1);
    offer_sample(DispMin, VelMin, 1'b1, 1'b1);
    // The first sample seeds the minimum and maximum, so zero is not part of
    // the span of an all-positive or all-negative block.
    offer_sample(1000, '0, 1'b0, 1'b0);
    offer_sample(2000, '0, 1'b1, 1'b0);
    offer_sample(-50, 24'sd1, 1'b0, 1'b1);
    offer_sample(-10, -24'sd1, 1'b1, 1'b1);

    pause_until_drained();

    // Random blocks. Half way through, the receiver holds off for a long
    // stretch while single-sample blocks keep coming, so the result queue
    // fills and the input stalls; after that the sender waits for the drain.
    while (items_sent < RandomItems) begin
      if (!hold_done && items_sent > RandomItems / 2) begin
        drain_hold_req = 1'b1;
        repeat (40) send_block(1, 1'b1);
        hold_done = 1'b1;
        pause_until_drained();
      end else begin
        send_block(pick_len(), $urandom_range(0, 4) == 0);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("block_vibration_statistics regression: pass");
    end else begin
      $display("block_vibration_statistics regression: fail");
    end
    $finish;
  end

endmodule
